/* hdl/papdc_pkg.sv */
// ----------------------------------------------------------------------------
// papdc_pkg
// Shared widths, register indexes and gesture codes of the pressure/attitude
// PD controller.
// ----------------------------------------------------------------------------
package papdc_pkg;

    // field widths
    localparam int PRESS_W = 27;
    localparam int BATT_W  = 19;
    localparam int SENS_W  = 32;
    localparam int CODE_W  = 4;
    localparam int GAIN_W  = 24;
    localparam int DRIVE_W = 48;
    localparam int CNT_W   = 5;

    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 192;

    localparam int CFG_IDX_W = 3;
    localparam int NUM_GAINS = 8;

    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic signed [DRIVE_W-1:0]  drive_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_P   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_I   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_D   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRUST_D = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_THRUST_I = 3'd7;

    // gesture codes
    localparam logic [CODE_W-1:0] GC_UP         = 4'd2;
    localparam logic [CODE_W-1:0] GC_DOWN       = 4'd3;
    localparam logic [CODE_W-1:0] GC_ROLL_LEFT  = 4'd4;
    localparam logic [CODE_W-1:0] GC_ROLL_RIGHT = 4'd5;
    localparam logic [CODE_W-1:0] GC_PITCH_UP   = 4'd6;
    localparam logic [CODE_W-1:0] GC_PITCH_DOWN = 4'd7;
    localparam logic [CODE_W-1:0] GC_YAW        = 4'd8;

    localparam gain_t RST_PITCH_P  = 24'd327680;
    localparam gain_t RST_PITCH_D  = 24'd655360;
    localparam gain_t RST_ROLL_P   = 24'd393216;
    localparam gain_t RST_ROLL_D   = 24'd655360;
    localparam gain_t RST_THRUST_D = 24'd6553600;

endpackage

/* hdl/pressure_attitude_pd_controller_unit.sv */
// Each accepted input word is run through three bit-serial shift-add multiplier
// lanes in four product phases back to back; no new word is accepted until the
// result word has been loaded into m_tdata.
// The window-average divide runs bit-serially beside them.
// Reset (aresetn low, synchronous) restores the gains, clears the error and
// pressure sums, sets the step counter to one and drops m_tvalid.
// ----------------------------------------------------------------------------
// pressure_attitude_pd_controller_unit
// Pitch/roll PID and pressure-based thrust controller, one sensor snapshot
// per word, fixed point with FRACTION_BITS fraction bits.
// ----------------------------------------------------------------------------
module pressure_attitude_pd_controller_unit #(
    parameter int WINDOW_LENGTH = 20,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pressure_reading, battery_volts, pitch_accel, roll_accel, pitch_rate,
    // roll_rate, gesture_code, zero pad
    input  logic [papdc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pitch_drive, roll_drive, yaw_drive, thrust_drive
    output logic [papdc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [papdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [papdc_pkg::GAIN_W-1:0]        cfg_data
);
    import papdc_pkg::*;

    localparam int LANES  = 3;
    localparam int LANE_P = 0;
    localparam int LANE_R = 1;
    localparam int LANE_T = 2;
    localparam int MAG_W  = 48;
    localparam int MB_W   = 32;
    localparam int ACC_W  = MAG_W + MB_W;
    localparam int OPA_W  = 49;
    localparam int TOT_W  = 50;
    localparam int ERR_W  = SENS_W + 1;
    localparam int CHG_W  = PRESS_W + 1;
    localparam int BIT_W  = 6;
    localparam int DIV_W  = 6;

    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(MB_W);
    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] WIN      = CNT_W'(WINDOW_LENGTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam longint ONE_L     = longint'(1) << FRACTION_BITS;
    localparam longint K_BASE_L  = ((longint'(408) << FRACTION_BITS) + 5) / 10;
    localparam longint K_SLOPE_L = ((longint'(13) << FRACTION_BITS) + 5) / 10;

    localparam logic signed [TOT_W-1:0] TRIM_PITCH = TOT_W'(-5 * ONE_L);
    localparam logic signed [TOT_W-1:0] TRIM_ROLL  = TOT_W'(6 * ONE_L);
    localparam logic signed [TOT_W-1:0] OFS_UP     = TOT_W'(4000 * ONE_L);
    localparam logic signed [TOT_W-1:0] OFS_DOWN   = TOT_W'(-8000 * ONE_L);
    localparam logic signed [TOT_W-1:0] OFS_ROLL   = TOT_W'(20 * ONE_L);
    localparam logic signed [TOT_W-1:0] OFS_PITCH  = TOT_W'(25 * ONE_L);
    localparam logic signed [TOT_W-1:0] K_BASE     = TOT_W'(K_BASE_L);
    localparam logic signed [OPA_W-1:0] FOUR       = OPA_W'(4 * ONE_L);
    localparam logic [MB_W-1:0]         K_SLOPE    = MB_W'(K_SLOPE_L);
    localparam drive_t                  YAW_VAL    = DRIVE_W'(200 * ONE_L);

    localparam logic [ACC_W-1:0] CAP   = ACC_W'(1) << (DRIVE_W - 1);
    localparam drive_t           MAX48 = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam drive_t           MIN48 = {1'b1, {(DRIVE_W-1){1'b0}}};

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    function automatic drive_t sat48(input logic signed [TOT_W-1:0] v);
        if (v > $signed(TOT_W'(MAX48)))
            return MAX48;
        else if (v < $signed({{(TOT_W-DRIVE_W){1'b1}}, MIN48}))
            return MIN48;
        else
            return v[DRIVE_W-1:0];
    endfunction

    // input fields
    logic [PRESS_W-1:0] f_press;
    logic [BATT_W-1:0]  f_batt;
    logic [SENS_W-1:0]  f_paccel, f_raccel, f_prate, f_rrate;
    logic [CODE_W-1:0]  f_code;

    assign f_press  = s_tdata[26:0];
    assign f_batt   = s_tdata[45:27];
    assign f_paccel = s_tdata[77:46];
    assign f_raccel = s_tdata[109:78];
    assign f_prate  = s_tdata[141:110];
    assign f_rrate  = s_tdata[173:142];
    assign f_code   = s_tdata[177:174];

    // control
    logic [1:0]        state_reg;
    logic [1:0]        phase_reg;
    logic [BIT_W-1:0]  bit_cnt_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              div_busy_reg;
    logic [DIV_W-1:0]  div_cnt_reg;

    gain_t             gain_reg [NUM_GAINS];

    // state
    drive_t            psum_reg, rsum_reg, csum_reg;
    logic [PRESS_W-1:0] last_press_reg;

    // per-word payload
    logic signed [ERR_W-1:0] errp_reg, errr_reg, errpr_reg, errrr_reg;
    logic [PRESS_W-1:0]      press_reg;
    logic [BATT_W-1:0]       batt_reg;
    logic signed [CHG_W-1:0] change_reg;
    logic [CODE_W-1:0]       code_reg;

    // divider
    logic [MAG_W-1:0]  dqp_reg, dqr_reg;
    logic [CNT_W-1:0]  remp_reg, remr_reg;
    logic              negp_reg, negr_reg;

    // multiplier lanes
    logic [MAG_W-1:0]        mag_reg [LANES];
    logic                    neg_reg [LANES];
    logic [MB_W-1:0]         b_reg   [LANES];
    logic [ACC_W-1:0]        acc_reg [LANES];
    logic signed [TOT_W-1:0] tot_reg [LANES];

    logic in_acc, out_go;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign out_go    = (state_reg == ST_DONE) && (!m_tvalid || m_tready);

    // accept-time state update
    logic signed [ERR_W-1:0] errp_in, errr_in;
    logic [CNT_W-1:0]        cnt_inc, cnt_next;
    logic                    win_hit;
    drive_t                  psum_next, rsum_next, csum_next;
    logic signed [CHG_W-1:0] change_in;
    logic signed [TOT_W-1:0] pinit, rinit, tinit;

    always_comb begin
        errp_in   = -$signed(ERR_W'($signed(f_paccel)));
        errr_in   = -$signed(ERR_W'($signed(f_raccel)));
        cnt_inc   = cnt_reg + CNT_ONE;
        win_hit   = (cnt_inc == WIN);
        cnt_next  = win_hit ? CNT_ONE : cnt_inc;
        psum_next = win_hit ? '0 : sat48(TOT_W'(psum_reg) + TOT_W'(errp_in));
        rsum_next = win_hit ? '0 : sat48(TOT_W'(rsum_reg) + TOT_W'(errr_in));
        change_in = $signed({1'b0, f_press}) - $signed({1'b0, last_press_reg});
        csum_next = sat48(TOT_W'(csum_reg) + TOT_W'(change_in));
        pinit = TRIM_PITCH;
        rinit = TRIM_ROLL;
        tinit = '0;
        case (f_code)
            GC_UP:         tinit = OFS_UP;
            GC_DOWN:       tinit = OFS_DOWN;
            GC_ROLL_LEFT:  rinit = TRIM_ROLL - OFS_ROLL;
            GC_ROLL_RIGHT: rinit = TRIM_ROLL + OFS_ROLL;
            GC_PITCH_UP:   pinit = TRIM_PITCH + OFS_PITCH;
            GC_PITCH_DOWN: pinit = TRIM_PITCH - OFS_PITCH;
            default:       ;
        endcase
    end

    // restoring divide step, one quotient bit per cycle
    logic [CNT_W-1:0] divisor;
    logic [CNT_W:0]   trialp, trialr;
    logic             qbitp, qbitr;
    logic [MAG_W-1:0] qp_next, qr_next;
    logic [CNT_W-1:0] remp_next, remr_next;

    always_comb begin
        divisor   = (cnt_reg == '0) ? CNT_ONE : cnt_reg;
        trialp    = {remp_reg, dqp_reg[MAG_W-1]};
        trialr    = {remr_reg, dqr_reg[MAG_W-1]};
        qbitp     = (trialp >= {1'b0, divisor});
        qbitr     = (trialr >= {1'b0, divisor});
        remp_next = qbitp ? CNT_W'(trialp - {1'b0, divisor}) : trialp[CNT_W-1:0];
        remr_next = qbitr ? CNT_W'(trialr - {1'b0, divisor}) : trialr[CNT_W-1:0];
        qp_next   = {dqp_reg[MAG_W-2:0], qbitp};
        qr_next   = {dqr_reg[MAG_W-2:0], qbitr};
    end

    // lane step, term finish and next operands
    logic [ACC_W-1:0]        acc_step [LANES];
    logic [ACC_W-1:0]        shifted  [LANES];
    logic [MAG_W-1:0]        capped   [LANES];
    drive_t                  term     [LANES];
    logic signed [OPA_W-1:0] opa      [LANES];
    logic [MB_W-1:0]         opb      [LANES];
    logic [1:0]              ld_ph;
    logic signed [TOT_W-1:0] kp_full;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            acc_step[l] = {acc_reg[l][ACC_W-2:0], 1'b0}
                        + (b_reg[l][MB_W-1] ? ACC_W'(mag_reg[l]) : '0);
            shifted[l]  = acc_reg[l] >> FRACTION_BITS;
            capped[l]   = (shifted[l] > CAP) ? CAP[MAG_W-1:0] : shifted[l][MAG_W-1:0];
            if (neg_reg[l])
                term[l] = -$signed(capped[l]);
            else if (capped[l] > MAX48)
                term[l] = MAX48;
            else
                term[l] = $signed(capped[l]);
        end
        kp_full = K_BASE - TOT_W'(term[LANE_T]);
        ld_ph   = (state_reg == ST_LOAD) ? 2'd0 : phase_reg + 2'd1;
        case (ld_ph)
            2'd0: begin
                opa[LANE_P] = OPA_W'(errp_reg);
                opb[LANE_P] = MB_W'(gain_reg[CFG_PITCH_P]);
                opa[LANE_R] = OPA_W'(errr_reg);
                opb[LANE_R] = MB_W'(gain_reg[CFG_ROLL_P]);
                opa[LANE_T] = FOUR - $signed(OPA_W'(batt_reg));
                opb[LANE_T] = K_SLOPE;
            end
            2'd1: begin
                opa[LANE_P] = OPA_W'(errpr_reg);
                opb[LANE_P] = MB_W'(gain_reg[CFG_PITCH_D]);
                opa[LANE_R] = OPA_W'(errrr_reg);
                opb[LANE_R] = MB_W'(gain_reg[CFG_ROLL_D]);
                opa[LANE_T] = $signed(OPA_W'(press_reg));
                opb[LANE_T] = kp_full[MB_W-1:0];
            end
            2'd2: begin
                opa[LANE_P] = OPA_W'(psum_reg);
                opb[LANE_P] = MB_W'(gain_reg[CFG_PITCH_I]);
                opa[LANE_R] = OPA_W'(rsum_reg);
                opb[LANE_R] = MB_W'(gain_reg[CFG_ROLL_I]);
                opa[LANE_T] = OPA_W'(csum_reg);
                opb[LANE_T] = MB_W'(gain_reg[CFG_THRUST_I]);
            end
            default: begin
                opa[LANE_P] = '0;
                opb[LANE_P] = '0;
                opa[LANE_R] = '0;
                opb[LANE_R] = '0;
                opa[LANE_T] = OPA_W'(change_reg);
                opb[LANE_T] = MB_W'(gain_reg[CFG_THRUST_D]);
            end
        endcase
    end

    logic load_ops, phase_end;
    assign phase_end = (state_reg == ST_RUN) && (bit_cnt_reg == BIT_LAST);
    assign load_ops  = (state_reg == ST_LOAD) || (phase_end && phase_reg != 2'd3);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            bit_cnt_reg  <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            m_tvalid     <= 1'b0;
        end else begin
            if (out_go)
                m_tvalid <= 1'b1;
            else if (m_tready)
                m_tvalid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc)
                        state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    state_reg    <= ST_RUN;
                    phase_reg    <= '0;
                    bit_cnt_reg  <= '0;
                    div_busy_reg <= 1'b1;
                    div_cnt_reg  <= '0;
                end
                ST_RUN: begin
                    if (bit_cnt_reg != BIT_LAST) begin
                        bit_cnt_reg <= bit_cnt_reg + BIT_W'(1);
                    end else if (phase_reg == 2'd3) begin
                        state_reg <= ST_DONE;
                    end else begin
                        phase_reg   <= phase_reg + 2'd1;
                        bit_cnt_reg <= '0;
                    end
                end
                ST_DONE: begin
                    if (out_go)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + DIV_W'(1);
                if (div_cnt_reg == DIV_LAST)
                    div_busy_reg <= 1'b0;
            end
        end
    end

    // gains, step counter and running sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg[CFG_PITCH_P]  <= RST_PITCH_P;
            gain_reg[CFG_PITCH_I]  <= '0;
            gain_reg[CFG_PITCH_D]  <= RST_PITCH_D;
            gain_reg[CFG_ROLL_P]   <= RST_ROLL_P;
            gain_reg[CFG_ROLL_I]   <= '0;
            gain_reg[CFG_ROLL_D]   <= RST_ROLL_D;
            gain_reg[CFG_THRUST_D] <= RST_THRUST_D;
            gain_reg[CFG_THRUST_I] <= '0;
            cnt_reg        <= CNT_ONE;
            psum_reg       <= '0;
            rsum_reg       <= '0;
            csum_reg       <= '0;
            last_press_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PITCH_P:  gain_reg[CFG_PITCH_P]  <= cfg_data;
                    CFG_PITCH_I:  gain_reg[CFG_PITCH_I]  <= cfg_data;
                    CFG_PITCH_D:  gain_reg[CFG_PITCH_D]  <= cfg_data;
                    CFG_ROLL_P:   gain_reg[CFG_ROLL_P]   <= cfg_data;
                    CFG_ROLL_I:   gain_reg[CFG_ROLL_I]   <= cfg_data;
                    CFG_ROLL_D:   gain_reg[CFG_ROLL_D]   <= cfg_data;
                    CFG_THRUST_D: gain_reg[CFG_THRUST_D] <= cfg_data;
                    CFG_THRUST_I: gain_reg[CFG_THRUST_I] <= cfg_data;
                    default:      ;
                endcase
            end
            if (in_acc) begin
                cnt_reg        <= cnt_next;
                psum_reg       <= psum_next;
                rsum_reg       <= rsum_next;
                csum_reg       <= csum_next;
                last_press_reg <= f_press;
            end else if (div_busy_reg && div_cnt_reg == DIV_LAST) begin
                // window average written back into the sums
                psum_reg <= negp_reg ? -$signed(qp_next) : $signed(qp_next);
                rsum_reg <= negr_reg ? -$signed(qr_next) : $signed(qr_next);
            end
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            errp_reg   <= errp_in;
            errr_reg   <= errr_in;
            errpr_reg  <= -$signed(ERR_W'($signed(f_prate)));
            errrr_reg  <= -$signed(ERR_W'($signed(f_rrate)));
            press_reg  <= f_press;
            batt_reg   <= f_batt;
            change_reg <= change_in;
            code_reg   <= f_code;
            tot_reg[LANE_P] <= pinit;
            tot_reg[LANE_R] <= rinit;
            tot_reg[LANE_T] <= tinit;
        end
        if (state_reg == ST_LOAD) begin
            negp_reg <= psum_reg[DRIVE_W-1];
            negr_reg <= rsum_reg[DRIVE_W-1];
            dqp_reg  <= psum_reg[DRIVE_W-1] ? MAG_W'(-psum_reg) : MAG_W'(psum_reg);
            dqr_reg  <= rsum_reg[DRIVE_W-1] ? MAG_W'(-rsum_reg) : MAG_W'(rsum_reg);
            remp_reg <= '0;
            remr_reg <= '0;
        end else if (div_busy_reg) begin
            dqp_reg  <= qp_next;
            dqr_reg  <= qr_next;
            remp_reg <= remp_next;
            remr_reg <= remr_next;
        end
        for (int l = 0; l < LANES; l++) begin
            if (phase_end && !(l == LANE_T && phase_reg == 2'd0))
                tot_reg[l] <= tot_reg[l] + TOT_W'(term[l]);
            if (load_ops) begin
                neg_reg[l] <= opa[l][OPA_W-1];
                mag_reg[l] <= opa[l][OPA_W-1] ? MAG_W'(-opa[l]) : MAG_W'(opa[l]);
                b_reg[l]   <= opb[l];
                acc_reg[l] <= '0;
            end else if (state_reg == ST_RUN && bit_cnt_reg != BIT_LAST) begin
                acc_reg[l] <= acc_step[l];
                b_reg[l]   <= {b_reg[l][MB_W-2:0], 1'b0};
            end
        end
        if (out_go) begin
            m_tdata[47:0]    <= sat48(tot_reg[LANE_P]);
            m_tdata[95:48]   <= sat48(tot_reg[LANE_R]);
            m_tdata[143:96]  <= (code_reg == GC_YAW) ? YAW_VAL : '0;
            m_tdata[191:144] <= sat48(tot_reg[LANE_T]);
        end
    end

`ifndef ASSERT_OFF
    // the averaged sums must be written back before the integral phase
    a_div_before_int: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_end && phase_reg == 2'd1) |-> !div_busy_reg)
        else $error("integral phase started before window divide finished");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) && (cnt_reg < WIN))
        else $error("step counter out of window");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside done state");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> !s_tready)
        else $error("input ready while datapath busy");
`endif

endmodule
